/* src/lfsm_pkg.sv */
// Package for the looper footswitch mode tracker.
// Holds mode and button codes, register indexes, and shared struct types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lfsm_pkg;

  localparam int unsigned FUNC_W      = 3;
  localparam int unsigned STAMP_W     = 32;
  localparam int unsigned HOLD_W      = 16;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

  localparam logic [HOLD_W-1:0]  RECORD_HOLD_RST   = 16'd500;
  localparam logic [HOLD_W-1:0]  ERASE_HOLD_RST    = 16'd2000;
  localparam logic [COUNT_W-1:0] ERASE_PRESSES_RST = 4'd3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_RECORD_PLAY = 3'd0,
    FUNC_REVERSE     = 3'd1,
    FUNC_HALF_TIME   = 3'd2,
    FUNC_UNDO        = 3'd3,
    FUNC_STOP_ERASE  = 3'd4,
    FUNC_TRIGGER     = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    MODE_EMPTY     = 3'd0,
    MODE_REC       = 3'd1,
    MODE_REC_UNDO  = 3'd2,
    MODE_PLAY      = 3'd3,
    MODE_DUB       = 3'd4,
    MODE_STOP      = 3'd5,
    MODE_ERASED    = 3'd6
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RECORD_HOLD   = 2'd0,
    CFG_ERASE_HOLD    = 2'd1,
    CFG_ERASE_PRESSES = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [HOLD_W-1:0]  record_hold;
    logic [HOLD_W-1:0]  erase_hold;
    logic [COUNT_W-1:0] erase_presses;
  } cfg_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic               is_press;
    logic [STAMP_W-1:0] now_ms;
  } evt_t;

  typedef struct packed {
    mode_e              mode;
    logic               reverse_flag;
    logic               half_flag;
    logic               layer_flag;
    logic [COUNT_W-1:0] stop_count;
    logic [STAMP_W-1:0] record_stamp;
    logic [STAMP_W-1:0] stop_stamp;
  } state_t;

endpackage

`default_nettype wire

/* src/lfsm_cfg.sv */
// Configuration register bank for the looper footswitch mode tracker.
// Depends on lfsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfsm_cfg (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire [lfsm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [lfsm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output lfsm_pkg::cfg_t                  cfg_o
);
  import lfsm_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RECORD_HOLD:   cfg_d.record_hold   = cfg_data_i[HOLD_W-1:0];
        CFG_ERASE_HOLD:    cfg_d.erase_hold    = cfg_data_i[HOLD_W-1:0];
        CFG_ERASE_PRESSES: cfg_d.erase_presses = cfg_data_i[COUNT_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.record_hold   <= RECORD_HOLD_RST;
      cfg_q.erase_hold    <= ERASE_HOLD_RST;
      cfg_q.erase_presses <= ERASE_PRESSES_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

/* src/lfsm_next.sv */
// Next-state logic of the looper footswitch mode tracker for one event.
// Depends on lfsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfsm_next (
  input  lfsm_pkg::state_t state_i,
  input  lfsm_pkg::evt_t   evt_i,
  input  lfsm_pkg::cfg_t   cfg_i,
  output lfsm_pkg::state_t state_o
);
  import lfsm_pkg::*;

  logic [STAMP_W-1:0] rec_diff;
  logic [STAMP_W-1:0] stop_diff;
  logic [COUNT_W-1:0] count_inc;
  mode_e              stop_mode;

  assign rec_diff  = evt_i.now_ms - state_i.record_stamp;
  assign stop_diff = evt_i.now_ms - state_i.stop_stamp;
  assign count_inc = (state_i.stop_count == COUNT_MAX) ? COUNT_MAX
                                                       : state_i.stop_count + 4'd1;

  always_comb begin
    stop_mode = state_i.mode;
    if (state_i.mode != MODE_ERASED && state_i.mode != MODE_EMPTY) begin
      stop_mode = MODE_STOP;
    end
    if (count_inc >= cfg_i.erase_presses && stop_mode != MODE_EMPTY) begin
      stop_mode = MODE_ERASED;
    end
  end

  always_comb begin
    state_o = state_i;
    case (evt_i.func)
      FUNC_RECORD_PLAY: begin
        if (evt_i.is_press) begin
          state_o.stop_count   = '0;
          state_o.record_stamp = evt_i.now_ms;
          unique case (state_i.mode)
            MODE_EMPTY, MODE_ERASED: begin
              state_o.mode       = MODE_REC;
              state_o.layer_flag = 1'b0;
            end
            MODE_PLAY: begin
              state_o.mode       = MODE_DUB;
              state_o.layer_flag = 1'b1;
            end
            MODE_REC, MODE_DUB, MODE_STOP: state_o.mode = MODE_PLAY;
            default:                       state_o.mode = state_i.mode;
          endcase
        end else if ((state_i.mode == MODE_REC || state_i.mode == MODE_DUB) &&
                     rec_diff > {{(STAMP_W-HOLD_W){1'b0}}, cfg_i.record_hold}) begin
          state_o.mode = MODE_PLAY;
        end
      end
      FUNC_REVERSE: begin
        if (evt_i.is_press) begin
          state_o.reverse_flag = ~state_i.reverse_flag;
        end
      end
      FUNC_HALF_TIME: begin
        if (evt_i.is_press) begin
          state_o.half_flag = ~state_i.half_flag;
        end
      end
      FUNC_UNDO: begin
        if (evt_i.is_press) begin
          state_o.stop_count = '0;
          unique case (state_i.mode)
            MODE_ERASED:   state_o.mode = MODE_PLAY;
            MODE_REC:      state_o.mode = MODE_REC_UNDO;
            MODE_REC_UNDO: state_o.mode = MODE_PLAY;
            MODE_PLAY:     state_o.mode = state_i.layer_flag ? MODE_PLAY : MODE_REC_UNDO;
            default:       state_o.mode = state_i.mode;
          endcase
        end
      end
      FUNC_STOP_ERASE: begin
        if (evt_i.is_press) begin
          state_o.stop_stamp = evt_i.now_ms;
          state_o.stop_count = count_inc;
          state_o.mode       = stop_mode;
        end else if (stop_diff >= {{(STAMP_W-HOLD_W){1'b0}}, cfg_i.erase_hold}) begin
          state_o.mode = MODE_ERASED;
        end
      end
      FUNC_TRIGGER: begin
        if (evt_i.is_press) begin
          state_o.stop_count = '0;
        end
      end
      default: state_o = state_i;
    endcase
  end

endmodule

`default_nettype wire

/* src/looper_footswitch_fsm_core.sv */
// Looper footswitch mode tracker: top level with input, state and result registers.
// Depends on lfsm_pkg, lfsm_cfg and lfsm_next.
// Each event is held in the input register, then its result is registered.
// Throughput: one event per cycle unless the output stalls; the state update is one
// combinational pass from the input register to the state and result registers.
// Reset: asynchronous, active low; mode empty, flags and count clear, stamps zero,
// registers at 500 / 2000 / 3, no items in flight.
`timescale 1ns / 1ps
`default_nettype none

module looper_footswitch_fsm_core (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire [lfsm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [lfsm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire [lfsm_pkg::FUNC_W-1:0]      func_i,
  input  wire                             is_press_i,
  input  wire [lfsm_pkg::STAMP_W-1:0]     now_ms_i,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic [2:0]                      looper_mode_o,
  output logic                            reversed_o,
  output logic                            half_time_o,
  output logic                            layered_o,
  output logic [lfsm_pkg::COUNT_W-1:0]    press_count_o
);
  import lfsm_pkg::*;

  cfg_t   cfg;
  evt_t   evt_q;
  state_t state_q;
  state_t state_d;
  logic   in_valid_q;
  logic   out_valid_q;
  logic   advance;
  logic   in_xfer;

  logic [2:0]         mode_out_q;
  logic               rev_out_q;
  logic               half_out_q;
  logic               layer_out_q;
  logic [COUNT_W-1:0] count_out_q;

  lfsm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lfsm_next u_next (
    .state_i (state_q),
    .evt_i   (evt_q),
    .cfg_i   (cfg),
    .state_o (state_d)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  // hold control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q           <= 1'b0;
      out_valid_q          <= 1'b0;
      state_q.mode         <= MODE_EMPTY;
      state_q.reverse_flag <= 1'b0;
      state_q.half_flag    <= 1'b0;
      state_q.layer_flag   <= 1'b0;
      state_q.stop_count   <= '0;
      state_q.record_stamp <= '0;
      state_q.stop_stamp   <= '0;
    end else begin
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // capture payloads
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      evt_q.func     <= func_i;
      evt_q.is_press <= is_press_i;
      evt_q.now_ms   <= now_ms_i;
    end
    if (advance) begin
      mode_out_q  <= state_d.mode;
      rev_out_q   <= state_d.reverse_flag;
      half_out_q  <= state_d.half_flag;
      layer_out_q <= state_d.layer_flag;
      count_out_q <= state_d.stop_count;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign looper_mode_o = mode_out_q;
  assign reversed_o    = rev_out_q;
  assign half_time_o   = half_out_q;
  assign layered_o     = layer_out_q;
  assign press_count_o = count_out_q;

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Testbench for looper_footswitch_fsm_core: drives footswitch events and register writes,
// predicts mode, flags and press count per event, and checks every result in order.
// Depends on lfsm_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
  import lfsm_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned PRINT_CAP      = 40;
  localparam int unsigned PHASE_ITEMS    = 100;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam logic [FUNC_W-1:0]    FUNC_SPARE_A   = 3'd6;
  localparam logic [FUNC_W-1:0]    FUNC_SPARE_B   = 3'd7;

  typedef enum int unsigned {
    PACE_FREE,
    PACE_SLOW_SENDER,
    PACE_SLOW_SINK,
    PACE_BOTH
  } pace_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic               rev;
    logic               half;
    logic               layer;
    logic [COUNT_W-1:0] count;
  } looper_view_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [FUNC_W-1:0]     func      = '0;
  logic                  is_press  = 1'b0;
  logic [STAMP_W-1:0]    now_ms    = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [2:0]            looper_mode;
  logic                  reversed;
  logic                  half_time;
  logic                  layered;
  logic [COUNT_W-1:0]    press_count;

  // predicted looper state and registers
  mode_e              cur_mode         = MODE_EMPTY;
  logic               rev_on           = 1'b0;
  logic               half_on          = 1'b0;
  logic               layer_on         = 1'b0;
  logic [COUNT_W-1:0] stop_presses     = '0;
  logic [STAMP_W-1:0] rec_stamp        = '0;
  logic [STAMP_W-1:0] stop_stamp       = '0;
  logic [HOLD_W-1:0]  hold_record      = RECORD_HOLD_RST;
  logic [HOLD_W-1:0]  hold_erase       = ERASE_HOLD_RST;
  logic [COUNT_W-1:0] presses_to_erase = ERASE_PRESSES_RST;

  looper_view_t       views_due[$];
  int unsigned        mismatches     = 0;
  int unsigned        stalled_cycles = 0;
  int unsigned        items_sent     = 0;
  int unsigned        results_seen   = 0;
  int unsigned        send_gap_pct   = 0;
  int unsigned        sink_stall_pct = 0;
  logic [STAMP_W-1:0] clock_ms       = '0;

  looper_footswitch_fsm_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .func_i       (func),
    .is_press_i   (is_press),
    .now_ms_i     (now_ms),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .looper_mode_o(looper_mode),
    .reversed_o   (reversed),
    .half_time_o  (half_time),
    .layered_o    (layered),
    .press_count_o(press_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_RECORD_HOLD:   hold_record = val;
      CFG_ERASE_HOLD:    hold_erase = val;
      CFG_ERASE_PRESSES: presses_to_erase = val[COUNT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void advance_looper(logic [FUNC_W-1:0] f, logic p, logic [STAMP_W-1:0] t);
    logic [STAMP_W-1:0] held;
    case (f)
      FUNC_RECORD_PLAY: begin
        if (p) begin
          stop_presses = '0;
          case (cur_mode)
            MODE_EMPTY, MODE_ERASED: begin
              cur_mode = MODE_REC;
              layer_on = 1'b0;
            end
            MODE_PLAY: begin
              cur_mode = MODE_DUB;
              layer_on = 1'b1;
            end
            MODE_REC, MODE_DUB, MODE_STOP: cur_mode = MODE_PLAY;
            default: ;
          endcase
          rec_stamp = t;
        end else if (cur_mode == MODE_REC || cur_mode == MODE_DUB) begin
          held = t - rec_stamp;
          if (held > {16'd0, hold_record}) cur_mode = MODE_PLAY;
        end
      end
      FUNC_REVERSE:   if (p) rev_on = !rev_on;
      FUNC_HALF_TIME: if (p) half_on = !half_on;
      FUNC_UNDO: begin
        if (p) begin
          stop_presses = '0;
          case (cur_mode)
            MODE_ERASED:   cur_mode = MODE_PLAY;
            MODE_REC:      cur_mode = MODE_REC_UNDO;
            MODE_REC_UNDO: cur_mode = MODE_PLAY;
            MODE_PLAY:     if (!layer_on) cur_mode = MODE_REC_UNDO;
            default: ;
          endcase
        end
      end
      FUNC_STOP_ERASE: begin
        if (p) begin
          stop_stamp = t;
          if (stop_presses != COUNT_MAX) stop_presses = stop_presses + 1'b1;
          if (cur_mode != MODE_ERASED && cur_mode != MODE_EMPTY) cur_mode = MODE_STOP;
          if (stop_presses >= presses_to_erase && cur_mode != MODE_EMPTY) cur_mode = MODE_ERASED;
        end else begin
          held = t - stop_stamp;
          if (held >= {16'd0, hold_erase}) cur_mode = MODE_ERASED;
        end
      end
      FUNC_TRIGGER: if (p) stop_presses = '0;
      default: ;
    endcase
  endfunction

  function automatic looper_view_t current_view();
    looper_view_t v;
    v.mode  = cur_mode;
    v.rev   = rev_on;
    v.half  = half_on;
    v.layer = layer_on;
    v.count = stop_presses;
    return v;
  endfunction

  function automatic void check_field(string name, logic [3:0] want_v, logic [3:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= PRINT_CAP)
        $display("%0t ns: %s expected %0d, got %0d", $time, name, want_v, got_v);
    end
  endfunction

  // track every transfer on the three channels
  always @(posedge clk) begin
    looper_view_t want;
    logic         moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        apply_register(cfg_index, cfg_data);
        moved = 1'b1;
      end
      if (in_valid && in_ready) begin
        advance_looper(func, is_press, now_ms);
        views_due.push_back(current_view());
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        results_seen++;
        if (views_due.size() == 0) begin
          mismatches++;
          if (mismatches <= PRINT_CAP)
            $display("%0t ns: result with nothing expected, got mode %0d count %0d",
                     $time, looper_mode, press_count);
        end else begin
          want = views_due.pop_front();
          check_field("looper_mode", {1'b0, want.mode}, {1'b0, looper_mode});
          check_field("reversed", {3'd0, want.rev}, {3'd0, reversed});
          check_field("half_time", {3'd0, want.half}, {3'd0, half_time});
          check_field("layered", {3'd0, want.layer}, {3'd0, layered});
          check_field("press_count", want.count, press_count);
        end
      end
    end
    stalled_cycles <= moved ? 0 : stalled_cycles + 1;
  end

  initial begin
    while (stalled_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  task automatic send_event(input logic [FUNC_W-1:0] f, input logic p,
                            input logic [STAMP_W-1:0] stamp);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    is_press <= p;
    now_ms   <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] rec, input logic [CFG_DATA_W-1:0] era,
                            input logic [CFG_DATA_W-1:0] prs, input bit poke_unused);
    logic [CFG_IDX_W-1:0]  idx[4];
    logic [CFG_DATA_W-1:0] val[4];
    int unsigned           n;
    idx[0] = CFG_RECORD_HOLD;
    val[0] = rec;
    idx[1] = CFG_ERASE_HOLD;
    val[1] = era;
    idx[2] = CFG_ERASE_PRESSES;
    val[2] = prs;
    idx[3] = CFG_UNUSED_IDX;
    val[3] = 16'($urandom);
    n = poke_unused ? 4 : 3;
    for (int unsigned k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [STAMP_W-1:0] hold_near(logic [HOLD_W-1:0] thr);
    int h;
    if ($urandom_range(3) == 0) return 32'($urandom_range(70000));
    h = int'(thr) + int'($urandom_range(4)) - 2;
    if (h < 0) h = 0;
    return 32'(h);
  endfunction

  // gestures with random timing around the thresholds, plus some raw noise
  task automatic run_phase(input logic [CFG_DATA_W-1:0] rec, input logic [CFG_DATA_W-1:0] era,
                           input logic [CFG_DATA_W-1:0] prs, input bit poke_unused,
                           input pace_e pace);
    int unsigned       first;
    int unsigned       pick;
    int unsigned       burst;
    logic [FUNC_W-1:0] which;
    set_config(rec, era, prs, poke_unused);
    case (pace)
      PACE_FREE: begin
        send_gap_pct   = 0;
        sink_stall_pct = 0;
      end
      PACE_SLOW_SENDER: begin
        send_gap_pct   = 78;
        sink_stall_pct = 0;
      end
      PACE_SLOW_SINK: begin
        send_gap_pct   = 0;
        sink_stall_pct = 78;
      end
      default: begin
        send_gap_pct   = 15;
        sink_stall_pct = 15;
      end
    endcase
    first = items_sent;
    while (items_sent - first < PHASE_ITEMS) begin
      pick = $urandom_range(99);
      if ($urandom_range(49) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(1, 3000);
      if (pick < 15) begin
        send_event(3'($urandom_range(7)), 1'($urandom_range(1)), $urandom);
      end else if (pick < 40) begin
        send_event(FUNC_RECORD_PLAY, 1'b1, clock_ms);
        clock_ms = clock_ms + hold_near(hold_record);
        send_event(FUNC_RECORD_PLAY, 1'b0, clock_ms);
      end else if (pick < 60) begin
        send_event(FUNC_STOP_ERASE, 1'b1, clock_ms);
        clock_ms = clock_ms + hold_near(hold_erase);
        send_event(FUNC_STOP_ERASE, 1'b0, clock_ms);
      end else if (pick < 72) begin
        burst = $urandom_range(1, 17);
        repeat (burst) begin
          send_event(FUNC_STOP_ERASE, 1'b1, clock_ms);
          clock_ms = clock_ms + $urandom_range(1, 300);
          send_event(FUNC_STOP_ERASE, 1'b0, clock_ms);
          clock_ms = clock_ms + $urandom_range(1, 300);
        end
      end else if (pick < 84) begin
        send_event(FUNC_UNDO, 1'b1, clock_ms);
        if ($urandom_range(1) == 1) send_event(FUNC_UNDO, 1'b0, clock_ms + 32'd40);
      end else if (pick < 94) begin
        which = ($urandom_range(1) == 1) ? FUNC_REVERSE : FUNC_HALF_TIME;
        send_event(which, 1'b1, clock_ms);
        send_event(which, 1'b0, clock_ms + 32'd60);
      end else begin
        send_event(FUNC_TRIGGER, 1'b1, clock_ms);
        send_event(FUNC_TRIGGER, 1'b0, clock_ms + 32'd30);
      end
    end
    wait_for_results();
  endtask

  task automatic test_mode_walk();
    send_event(FUNC_STOP_ERASE, 1'b0, 32'd1999);
    send_event(FUNC_STOP_ERASE, 1'b1, 32'd0);
    send_event(FUNC_TRIGGER, 1'b1, 32'd0);
    send_event(FUNC_STOP_ERASE, 1'b0, 32'd2000);
    send_event(FUNC_STOP_ERASE, 1'b1, 32'd2100);
    send_event(FUNC_SPARE_B, 1'b1, 32'hFFFF_FFFF);
    send_event(FUNC_SPARE_A, 1'b0, 32'h1234_5678);
    send_event(FUNC_RECORD_PLAY, 1'b1, 32'hFFFF_FF00);
    send_event(FUNC_RECORD_PLAY, 1'b0, 32'h0000_00F4);
    send_event(FUNC_UNDO, 1'b1, 32'd10);
    send_event(FUNC_RECORD_PLAY, 1'b1, 32'd100);
    send_event(FUNC_UNDO, 1'b0, 32'd110);
    send_event(FUNC_UNDO, 1'b1, 32'd120);
    send_event(FUNC_UNDO, 1'b1, 32'd130);
    send_event(FUNC_UNDO, 1'b1, 32'd140);
    send_event(FUNC_RECORD_PLAY, 1'b1, 32'd1000);
    send_event(FUNC_RECORD_PLAY, 1'b0, 32'd1501);
    send_event(FUNC_UNDO, 1'b1, 32'd1600);
    send_event(FUNC_REVERSE, 1'b1, 32'd1700);
    send_event(FUNC_REVERSE, 1'b0, 32'd1710);
    send_event(FUNC_HALF_TIME, 1'b1, 32'd1720);
    send_event(FUNC_HALF_TIME, 1'b0, 32'd1730);
    send_event(FUNC_TRIGGER, 1'b0, 32'd1740);
    send_event(FUNC_STOP_ERASE, 1'b1, 32'd5000);
    send_event(FUNC_STOP_ERASE, 1'b0, 32'd6999);
    send_event(FUNC_RECORD_PLAY, 1'b1, 32'd7000);
    send_event(FUNC_STOP_ERASE, 1'b1, 32'd7100);
    send_event(FUNC_STOP_ERASE, 1'b1, 32'd7200);
    send_event(FUNC_STOP_ERASE, 1'b1, 32'd7300);
    send_event(FUNC_UNDO, 1'b1, 32'd7400);
    wait_for_results();
  endtask

  task automatic test_zero_press_threshold();
    set_config(RECORD_HOLD_RST, ERASE_HOLD_RST, 16'd0, 1'b0);
    send_event(FUNC_STOP_ERASE, 1'b1, 32'd9000);
    send_event(FUNC_UNDO, 1'b1, 32'd9100);
    send_event(FUNC_RECORD_PLAY, 1'b1, 32'd9200);
    send_event(FUNC_STOP_ERASE, 1'b1, 32'd9300);
    wait_for_results();
  endtask

  task automatic test_register_extremes();
    run_phase(16'd0, 16'd0, 16'd1, 1'b0, PACE_FREE);
    run_phase(16'hFFFF, 16'hFFFF, 16'd15, 1'b1, PACE_SLOW_SENDER);
    run_phase(16'd0, 16'hFFFF, {12'($urandom), 4'd0}, 1'b0, PACE_SLOW_SINK);
    run_phase(16'hFFFF, 16'd0, {12'($urandom), 4'd1}, 1'b1, PACE_BOTH);
  endtask

  task automatic test_random_registers();
    logic [CFG_DATA_W-1:0] rec;
    logic [CFG_DATA_W-1:0] era;
    for (int unsigned k = 0; k < 4; k++) begin
      rec = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3000));
      era = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3000));
      run_phase(rec, era, 16'($urandom), 1'($urandom_range(1)), pace_e'(k));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_mode_walk();
    test_zero_press_threshold();
    test_register_extremes();
    test_random_registers();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
